// File: sv/rso_pkg.sv
`timescale 1ns / 1ps

package rso_pkg;

  // Geometry and store size
  localparam int TEXEL_DEPTH = 65536;
  localparam int TEX_ADDR_W  = $clog2(TEXEL_DEPTH);
  localparam int COORD_BITS  = 12;
  localparam int SCALE_FRAC  = 12;
  localparam int POS_FRAC    = 8;

  // Field and register widths
  localparam int PIXEL_W    = 32;
  localparam int INDEX_W    = 16;
  localparam int SCALE_W    = 17;
  localparam int OFS_W      = 24;
  localparam int CLIP_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CHAN_W     = 8;

  localparam logic [SCALE_W-1:0] SCALE_COS_RESET = SCALE_W'(256);
  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE    = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_COS   = 3'd0,
    CFG_SCALE_SIN   = 3'd1,
    CFG_OFFSET_X    = 3'd2,
    CFG_OFFSET_Y    = 3'd3,
    CFG_CLIP_WIDTH  = 3'd4,
    CFG_CLIP_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } item_kind_t;

endpackage

// File: sv/rso_if.sv
`timescale 1ns / 1ps

interface rso_in_if;
  import rso_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [INDEX_W-1:0]    texel_index;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [PIXEL_W-1:0]    word;

  modport source (output valid, kind, texel_index, col, row, word, input ready);
  modport sink   (input valid, kind, texel_index, col, row, word, output ready);
endinterface

interface rso_out_if;
  import rso_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_pixel;
  logic               covered;

  modport source (output valid, out_pixel, covered, input ready);
  modport sink   (input valid, out_pixel, covered, output ready);
endinterface

// File: sv/rotated_sprite_alpha_overlay.sv
`timescale 1ns / 1ps

// Channel      Dir  Payload                               Handshake
// pixels_in    in   kind, texel_index, col, row, word     valid / ready
// pixels_out   out  out_pixel, covered                    valid / ready
// cfg          in   cfg_index, cfg_data                   cfg_we, no wait
//
// One request per clock sustained while pixels_out.ready holds; a pixel result passes
// through each stage register in turn before it leaves. Loads give no result and write
// the store at the same stage where pixels read it, so store order follows request
// order. The texture store is one single-port RAM, touched once per cycle.
// Reset clears stage valid bits and loads register defaults; the store is not cleared.
// Each stage holds only while its successor is full, so bubbles are squeezed out
// and input is taken while a finished result waits at the output.

module rotated_sprite_alpha_overlay (
  input  logic                       clk,
  input  logic                       rst,
  rso_in_if.sink                     pixels_in,
  rso_out_if.source                  pixels_out,
  input  logic                       cfg_we,
  input  logic [rso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rso_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rso_pkg::*;

  localparam int PX_W       = ((OFS_W > COORD_BITS + POS_FRAC + 1) ? OFS_W
                                : COORD_BITS + POS_FRAC + 1) + 1;
  localparam int PROD_W     = PX_W + SCALE_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int SHIFT      = SCALE_FRAC + POS_FRAC;
  localparam int XY_W       = SUM_W - SHIFT;
  localparam int LIN_W      = 2 * CLIP_W + 1;
  localparam int ADDR_SUM_W = (TEX_ADDR_W > LIN_W) ? TEX_ADDR_W : LIN_W;

  // configuration
  logic signed [SCALE_W-1:0] scale_cos, scale_sin;
  logic signed [OFS_W-1:0]   offset_x, offset_y;
  logic [CLIP_W-1:0]         clip_width, clip_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_cos   <= SCALE_COS_RESET;
      scale_sin   <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
      clip_width  <= '0;
      clip_height <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SCALE_COS:   scale_cos   <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_SIN:   scale_sin   <= cfg_data[SCALE_W-1:0];
        CFG_OFFSET_X:    offset_x    <= cfg_data[OFS_W-1:0];
        CFG_OFFSET_Y:    offset_y    <= cfg_data[OFS_W-1:0];
        CFG_CLIP_WIDTH:  clip_width  <= cfg_data[CLIP_W-1:0];
        CFG_CLIP_HEIGHT: clip_height <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || pixels_out.ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pixels_in.ready = en1;

  // stage registers
  logic                     s1_kind, s2_kind, s3_kind, s4_kind;
  logic [INDEX_W-1:0]       s1_idx, s2_idx, s3_idx;
  logic [PIXEL_W-1:0]       s1_word, s2_word, s3_word, s4_word, s5_word;
  logic signed [PX_W-1:0]   s1_px, s1_py;
  logic signed [PROD_W-1:0] s2_xc, s2_ys, s2_yc, s2_xs;
  logic                     s3_cov, s4_cov, s5_cov;
  logic [CLIP_W-1:0]        s3_x, s3_y;
  logic [TEX_ADDR_W-1:0]    s4_addr;
  logic [PIXEL_W-1:0]       s6_pixel;
  logic                     s6_cov;
  logic [PIXEL_W-1:0]       tex;

  // stage 1: position with offset
  logic signed [PX_W-1:0] colx, rowy, px, py;

  always_comb begin
    colx = PX_W'({1'b0, pixels_in.col, {POS_FRAC{1'b0}}});
    rowy = PX_W'({1'b0, pixels_in.row, {POS_FRAC{1'b0}}});
    px   = PX_W'(offset_x) + colx;
    py   = PX_W'(offset_y) + rowy;
  end

  // stage 3: rotate, floor shift, bounds
  logic signed [SUM_W-1:0] xs, ys;
  logic [XY_W-1:0]         xw, yw;
  logic                    in_clip;

  always_comb begin
    xs = SUM_W'(s2_xc) + SUM_W'(s2_ys);
    ys = SUM_W'(s2_yc) - SUM_W'(s2_xs);
    xw = xs[SUM_W-1:SHIFT];
    yw = ys[SUM_W-1:SHIFT];
    in_clip = !xw[XY_W-1] && !yw[XY_W-1]
              && (xw < XY_W'(clip_width)) && (yw < XY_W'(clip_height));
  end

  // stage 4: linear store address
  logic [ADDR_SUM_W-1:0] lin_addr, load_addr;

  always_comb begin
    lin_addr  = ADDR_SUM_W'(s3_x) + ADDR_SUM_W'(s3_y) * ADDR_SUM_W'(clip_width);
    load_addr = ADDR_SUM_W'(s3_idx);
  end

  // stage 6: alpha blend
  logic [CHAN_W-1:0]   alpha, inv_alpha;
  logic [2*CHAN_W-1:0] mix_r, mix_g, mix_b;
  logic [PIXEL_W-1:0]  blended;

  always_comb begin
    alpha     = tex[31:24];
    inv_alpha = ALPHA_OPAQUE - alpha;
    mix_r = 16'(tex[23:16] * alpha) + 16'(s5_word[23:16] * inv_alpha);
    mix_g = 16'(tex[15:8] * alpha)  + 16'(s5_word[15:8] * inv_alpha);
    mix_b = 16'(tex[7:0] * alpha)   + 16'(s5_word[7:0] * inv_alpha);
    if (alpha == ALPHA_OPAQUE) begin
      blended = {8'h00, tex[23:0]};
    end else begin
      blended = {8'h00, mix_r[15:8], mix_g[15:8], mix_b[15:8]};
    end
  end

  // texture store: loads write, pixels read, both between stages 4 and 5
  rso_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(TEXEL_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (en5 && v4),
    .we    (s4_kind == KIND_LOAD),
    .addr  (s4_addr),
    .wdata (s4_word),
    .rdata (tex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= pixels_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4 && (s4_kind == KIND_PIXEL);
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_kind <= pixels_in.kind;
      s1_idx  <= pixels_in.texel_index;
      s1_word <= pixels_in.word;
      s1_px   <= px;
      s1_py   <= py;
    end
    if (en2) begin
      s2_kind <= s1_kind;
      s2_idx  <= s1_idx;
      s2_word <= s1_word;
      s2_xc   <= PROD_W'(s1_px) * PROD_W'(scale_cos);
      s2_ys   <= PROD_W'(s1_py) * PROD_W'(scale_sin);
      s2_yc   <= PROD_W'(s1_py) * PROD_W'(scale_cos);
      s2_xs   <= PROD_W'(s1_px) * PROD_W'(scale_sin);
    end
    if (en3) begin
      s3_kind <= s2_kind;
      s3_idx  <= s2_idx;
      s3_word <= s2_word;
      s3_cov  <= in_clip;
      s3_x    <= xw[CLIP_W-1:0];
      s3_y    <= yw[CLIP_W-1:0];
    end
    if (en4) begin
      s4_kind <= s3_kind;
      s4_word <= s3_word;
      s4_cov  <= s3_cov;
      s4_addr <= (s3_kind == KIND_PIXEL) ? lin_addr[TEX_ADDR_W-1:0]
                                         : load_addr[TEX_ADDR_W-1:0];
    end
    if (en5) begin
      s5_word <= s4_word;
      s5_cov  <= s4_cov;
    end
    if (en6) begin
      s6_pixel <= s5_cov ? blended : s5_word;
      s6_cov   <= s5_cov;
    end
  end

  assign pixels_out.valid     = v6;
  assign pixels_out.out_pixel = s6_pixel;
  assign pixels_out.covered   = s6_cov;

endmodule

// File: sv/rso_ram.sv
`timescale 1ns / 1ps

module rso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: sv/rso_checker.sv
`timescale 1ns / 1ps

module rso_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rso_pkg::PIXEL_W-1:0] out_pixel,
  input logic                        out_covered
);
  import rso_pkg::*;

  localparam int MAX_INFLIGHT = 6;

  // pixel requests taken but not yet answered
  logic [3:0] inflight, inflight_next;

  always_comb begin
    inflight_next = inflight;
    if (in_valid && in_ready && (in_kind == KIND_PIXEL)) begin
      inflight_next = inflight_next + 4'd1;
    end
    if (out_valid && out_ready) begin
      inflight_next = inflight_next - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 4'd0)
    else $error("result without a pending pixel request");

  a_bounded_inflight: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(MAX_INFLIGHT))
    else $error("more pixel requests in flight than pipeline stages");

  a_covered_clears_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_covered |-> out_pixel[31:24] == 8'h00)
    else $error("covered pixel keeps a non-zero top byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_covered))
    else $error("stalled result changed");

endmodule

bind rotated_sprite_alpha_overlay rso_checker u_rso_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixels_in.valid),
  .in_ready    (pixels_in.ready),
  .in_kind     (pixels_in.kind),
  .out_valid   (pixels_out.valid),
  .out_ready   (pixels_out.ready),
  .out_pixel   (pixels_out.out_pixel),
  .out_covered (pixels_out.covered)
);
